// File: hdl/gif_lzw_decoder_assert.svh
// assertion macros for the gif lzw decoder
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define GLZW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GLZW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GLZW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GLZW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/glzw_pkg.sv
// shared types and constants of the gif lzw decoder
package glzw_pkg;
    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_LIM  = 2'd3;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    localparam logic [0:0] REG_MIN_SIZE = 1'b0;
    localparam logic [0:0] REG_LIMIT    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_KW_FIX,
        S_POP,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       pixel_valid;
        logic       need_byte;
        logic [1:0] status;
    } result_t;
endpackage

// File: hdl/glzw_if.sv
// valid/ready channel interfaces for the gif lzw decoder
interface glzw_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    modport source (output valid, output mode, output data_byte, input ready);
    modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface glzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       pixel_valid;
    logic       need_byte;
    logic [1:0] status;
    modport source (output valid, output pixel, output pixel_valid, output need_byte,
                    output status, input ready);
    modport sink (input valid, input pixel, input pixel_valid, input need_byte,
                  input status, output ready);
endinterface

// File: hdl/gif_lzw_decoder.sv
// top level of the gif lzw decoder
// usage: requests arrive on in_ch; mode 0 pushes one stream byte (length bytes
// open a sub-block, data bytes enter a 24-bit accumulator lsb first), mode 1
// pulls one pixel. every request yields exactly one result on out_ch carrying
// pixel, pixel_valid, need_byte and status.
// configuration: apb writes to min_code_size (0x0) and data_length_limit (0x4),
// only while idle.
// flow: a push goes from idle through out to the result register; a pull passes
// decode, pop and out, and one that pops a pending pixel or meets a clear or end
// code goes that way. a pull that decodes a new code walks the table between decode
// and pop: a table read, then a stack write per chained string character, a stack
// write for the root character, and a kwkwk fix state in the kwkwk case.
// throughput: one request at a time; the next is taken only once the fsm is back
// in idle and no result is pending or out ready is high.
// reset: control state clears, code width and next code follow the minimum
// code size of 8; table and stack memories are not cleared.
// stall: while a result waits with out ready low, it holds and no new request is taken.
module gif_lzw_decoder #(
    parameter int TABLE_DEPTH   = glzw_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    glzw_in_if.sink     in_ch,
    glzw_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import glzw_pkg::*;
`include "gif_lzw_decoder_assert.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;

    // configuration registers
    logic [3:0]  min_size_reg;
    logic [23:0] limit_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_MIN_SIZE: prdata = {28'd0, min_size_reg};
            REG_LIMIT:    prdata = {8'd0, limit_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // effective code size saturated to 1..8
    logic [3:0] eff_size;
    always_comb
    begin
        if (min_size_reg < 4'd1)
            eff_size = 4'd1;
        else if (min_size_reg > 4'd8)
            eff_size = 4'd8;
        else
            eff_size = min_size_reg;
    end
    logic [12:0] clr_code;
    logic [12:0] end_code;
    assign clr_code = 13'd1 << eff_size;
    assign end_code = clr_code + 13'd1;

    // memories
    logic [11:0] prefix_mem [TABLE_DEPTH];
    logic [7:0]  suffix_mem [TABLE_DEPTH];
    logic [7:0]  stack_mem  [TABLE_DEPTH];

    // state
    fsm_t        state_reg, state_next;
    logic [SW-1:0] stack_cnt_reg;
    logic [23:0] acc_reg;
    logic [4:0]  held_reg;
    logic [7:0]  blk_left_reg;
    logic [3:0]  width_reg;
    logic [12:0] free_reg;
    logic [11:0] prev_reg;
    logic        after_clr_reg;
    logic [23:0] remain_reg;
    logic [1:0]  status_reg;
    logic [12:0] walk_reg;
    logic        kw_reg;
    logic        add_reg;
    logic [11:0] code_reg;
    logic [7:0]  first_reg;
    result_t     res_reg;
    logic        out_valid_reg;
    logic        mode_reg;
    logic [7:0]  byte_reg;

    logic [11:0] tab_pre_q;
    logic [7:0]  tab_suf_q;
    logic [7:0]  stack_q;

    // control flow
    logic        take;
    logic        walk_leaf;
    logic [12:0] code_w;
    assign in_ch.ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign take = in_ch.valid && in_ch.ready;
    assign walk_leaf = (walk_reg <= end_code) || (walk_reg >= 13'(TABLE_DEPTH));
    assign code_w = 13'((acc_reg & ((24'd1 << width_reg) - 24'd1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (take)
                    state_next = (in_ch.mode == MODE_PULL) ? S_DECODE : S_OUT;
            S_DECODE:
                if (stack_cnt_reg == '0 && status_reg != ST_END && held_reg >= 5'(width_reg)
                    && code_w != clr_code && code_w != end_code)
                    state_next = S_WALK;
                else
                    state_next = S_POP;
            S_WALK:
                if (stack_cnt_reg[AW] || walk_leaf)
                    state_next = kw_reg ? S_KW_FIX : S_POP;
            S_KW_FIX: state_next = S_POP;
            S_POP:    state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // table read at the walk pointer
    always_ff @(posedge clk)
    begin
        tab_pre_q <= prefix_mem[walk_reg[AW-1:0]];
        tab_suf_q <= suffix_mem[walk_reg[AW-1:0]];
    end

    // stack read of the top entry, registered
    logic [SW-1:0] top_idx;
    assign top_idx = stack_cnt_reg - SW'(1);
    always_ff @(posedge clk)
    begin
        stack_q <= stack_mem[top_idx[AW-1:0]];
    end

    // walk phase: table read issued, then its data used
    logic walk_ph_reg;

    // datapath and memory writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_size_reg  <= 4'd8;
            limit_reg     <= 24'hFFFFFF;
            stack_cnt_reg <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            blk_left_reg  <= '0;
            width_reg     <= 4'd9;
            free_reg      <= 13'd258;
            prev_reg      <= '0;
            after_clr_reg <= 1'b0;
            remain_reg    <= 24'hFFFFFF;
            status_reg    <= ST_RUN;
            out_valid_reg <= 1'b0;
            walk_ph_reg   <= 1'b0;
            walk_reg      <= '0;
            kw_reg        <= 1'b0;
            add_reg       <= 1'b0;
            code_reg      <= '0;
            first_reg     <= '0;
            mode_reg      <= 1'b0;
            byte_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            // configuration writes
            if (cfg_wr && paddr[2] == REG_MIN_SIZE)
            begin
                min_size_reg <= pwdata[3:0];
                if (pwdata[3:0] <= 4'd1)
                begin
                    width_reg <= 4'd2;
                    free_reg  <= 13'd4;
                end
                else if (pwdata[3:0] >= 4'd8)
                begin
                    width_reg <= 4'd9;
                    free_reg  <= 13'd258;
                end
                else
                begin
                    width_reg <= pwdata[3:0] + 4'd1;
                    free_reg  <= (13'd1 << pwdata[3:0]) + 13'd2;
                end
            end
            if (cfg_wr && paddr[2] == REG_LIMIT)
            begin
                limit_reg  <= pwdata[23:0];
                remain_reg <= pwdata[23:0];
            end
            case (state_reg)
                S_IDLE:
                    if (take)
                    begin
                        mode_reg <= in_ch.mode;
                        byte_reg <= in_ch.data_byte;
                        res_reg.pixel_valid <= 1'b0;
                    end
                S_DECODE:
                    if (stack_cnt_reg == '0 && status_reg != ST_END
                        && held_reg >= 5'(width_reg))
                    begin
                        acc_reg  <= acc_reg >> width_reg;
                        held_reg <= held_reg - 5'(width_reg);
                        code_reg <= code_w[11:0];
                        walk_ph_reg <= 1'b0;
                        if (code_w == clr_code)
                        begin
                            width_reg     <= eff_size + 4'd1;
                            free_reg      <= clr_code + 13'd2;
                            after_clr_reg <= 1'b1;
                        end
                        else if (code_w == end_code)
                            status_reg <= ST_END;
                        else if (after_clr_reg)
                        begin
                            walk_reg <= code_w; kw_reg <= 1'b0; add_reg <= 1'b0;
                        end
                        else if (code_w < free_reg)
                        begin
                            walk_reg <= code_w; kw_reg <= 1'b0; add_reg <= 1'b1;
                        end
                        else
                        begin
                            walk_reg <= {1'b0, prev_reg}; kw_reg <= 1'b1; add_reg <= 1'b1;
                            stack_cnt_reg <= SW'(1);
                        end
                    end
                S_WALK:
                    // phase 0 issues the table read, phase 1 uses it
                    if (stack_cnt_reg[AW])
                        ;
                    else if (walk_leaf)
                    begin
                        stack_mem[stack_cnt_reg[AW-1:0]] <= walk_reg[7:0];
                        stack_cnt_reg <= stack_cnt_reg + SW'(1);
                        first_reg <= walk_reg[7:0];
                    end
                    else if (!walk_ph_reg)
                        walk_ph_reg <= 1'b1;
                    else
                    begin
                        walk_ph_reg <= 1'b0;
                        stack_mem[stack_cnt_reg[AW-1:0]] <= tab_suf_q;
                        stack_cnt_reg <= stack_cnt_reg + SW'(1);
                        first_reg <= tab_suf_q;
                        walk_reg <= {1'b0, tab_pre_q};
                    end
                S_KW_FIX:
                    stack_mem[0] <= first_reg;
                default: ;
            endcase
            // leaving the walk: table entry, previous code, width
            if (state_reg == S_WALK && state_next != S_WALK)
            begin
                after_clr_reg <= 1'b0;
                prev_reg <= code_reg;
                if (add_reg && free_reg < 13'(TABLE_DEPTH))
                begin
                    prefix_mem[free_reg[AW-1:0]] <= prev_reg;
                    suffix_mem[free_reg[AW-1:0]] <= stack_cnt_reg[AW] ? first_reg
                                                                       : walk_reg[7:0];
                    free_reg <= free_reg + 13'd1;
                    if ((free_reg + 13'd1) >= (13'd1 << width_reg)
                        && width_reg < 4'(MAX_CODE_BITS))
                        width_reg <= width_reg + 4'd1;
                end
            end
            // pop: stack read is issued in pop, result formed in out
            if (state_reg == S_POP && stack_cnt_reg != '0)
                stack_cnt_reg <= stack_cnt_reg - SW'(1);
            if (state_reg == S_POP)
                res_reg.pixel_valid <= mode_reg == MODE_PULL && stack_cnt_reg != '0;
            // push handling
            if (state_reg == S_IDLE && take && in_ch.mode == MODE_PUSH
                && status_reg == ST_RUN)
            begin
                if (blk_left_reg == 8'd0)
                begin
                    if (in_ch.data_byte == 8'd0)
                        status_reg <= ST_ZERO;
                    else if (24'(in_ch.data_byte) > remain_reg)
                        status_reg <= ST_LIM;
                    else
                    begin
                        remain_reg   <= remain_reg - 24'(in_ch.data_byte);
                        blk_left_reg <= in_ch.data_byte;
                    end
                end
                else
                begin
                    blk_left_reg <= blk_left_reg - 8'd1;
                    if (held_reg <= 5'd16)
                    begin
                        acc_reg  <= acc_reg | (24'(in_ch.data_byte) << held_reg);
                        held_reg <= held_reg + 5'd8;
                    end
                end
            end
            if (state_reg == S_OUT)
            begin
                out_valid_reg      <= 1'b1;
                res_reg.pixel      <= res_reg.pixel_valid ? stack_q : 8'd0;
                res_reg.need_byte  <= stack_cnt_reg == '0 && held_reg < 5'(width_reg);
                res_reg.status     <= status_reg;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel       = res_reg.pixel;
    assign out_ch.pixel_valid = res_reg.pixel_valid;
    assign out_ch.need_byte   = res_reg.need_byte;
    assign out_ch.status      = res_reg.status;

    // checks
    `GLZW_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == S_IDLE)
    `GLZW_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(res_reg))
    `GLZW_ASSERT_IMP(a_stack_bound, clk, rst_n, 1'b1, stack_cnt_reg <= SW'(TABLE_DEPTH))
    `GLZW_ASSERT_IMP(a_width_bound, clk, rst_n, 1'b1, width_reg <= 4'(MAX_CODE_BITS))
endmodule

// File: bench/tb_gif_lzw_decoder.sv
// self-checking testbench of the gif lzw decoder: stream builder, predictor and checker
module tb_gif_lzw_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import glzw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DEPTH          = 4096;

    typedef struct {
        logic       mode;
        logic [7:0] data;
    } request_t;

    typedef enum int {K_ANY, K_ROOT, K_TOPROOT, K_CLEAR, K_KW, K_OLD, K_TOP} code_kind_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glzw_in_if  in_ch ();
    glzw_out_if out_ch ();

    gif_lzw_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pending requests and the results they must produce
    request_t request_q[$];
    result_t  pixel_q[$];
    int       errors;
    int       idle_pct;
    int       send_gap;
    int       sink_stall;
    int       watchdog;

    // decoder state as predicted
    int unsigned min_size;
    bit [11:0]   prefix_mem [DEPTH];
    bit [7:0]    suffix_mem [DEPTH];
    bit [7:0]    pix_stack [DEPTH];
    bit          entry_set [DEPTH];
    int unsigned stack_cnt;
    int unsigned bit_acc;
    int unsigned bits_in;
    int unsigned block_left;
    int unsigned width;
    int unsigned free_code;
    int unsigned last_code;
    bit          cleared;
    int unsigned budget;
    logic [1:0]  dec_status;

    // what the run went through
    int n_requests;
    int n_pixels;
    int n_clears;
    int n_kwkwk;
    int n_full;

    function automatic int unsigned size_used();
        return (min_size < 1) ? 1 : ((min_size > 8) ? 8 : min_size);
    endfunction

    function automatic int unsigned clear_code();
        return 1 << size_used();
    endfunction

    function automatic void restart_codes();
        width     = size_used() + 1;
        free_code = clear_code() + 2;
    endfunction

    // stack the string of a code, last character first
    function automatic void unwind_string(int unsigned c);
        while (stack_cnt < DEPTH)
        begin
            if (c <= clear_code() + 1 || c >= DEPTH)
            begin
                pix_stack[stack_cnt] = 8'(c);
                stack_cnt++;
                return;
            end
            pix_stack[stack_cnt] = suffix_mem[c];
            stack_cnt++;
            c = prefix_mem[c];
        end
    endfunction

    function automatic void decode_code(int unsigned code);
        bit [7:0] first;
        if (code == clear_code())
        begin
            restart_codes();
            cleared = 1'b1;
            n_clears++;
            return;
        end
        if (code == clear_code() + 1)
        begin
            dec_status = ST_END;
            return;
        end
        if (cleared)
        begin
            unwind_string(code);
            cleared   = 1'b0;
            last_code = code & 12'hFFF;
            return;
        end
        if (code < free_code)
        begin
            unwind_string(code);
            first = pix_stack[stack_cnt - 1];
        end
        else
        begin
            // kwkwk: previous string plus its own first character
            stack_cnt = 1;
            unwind_string(last_code);
            first = pix_stack[stack_cnt - 1];
            pix_stack[0] = first;
            n_kwkwk++;
        end
        if (free_code < DEPTH)
        begin
            prefix_mem[free_code] = 12'(last_code);
            suffix_mem[free_code] = first;
            entry_set[free_code]  = 1'b1;
            free_code++;
        end
        else
            n_full++;
        last_code = code & 12'hFFF;
        if (free_code >= (1 << width) && width < MAX_CODE_BITS_DEF)
            width++;
    endfunction

    function automatic void push_stream_byte(bit [7:0] b);
        if (dec_status != ST_RUN)
            return;
        if (block_left == 0)
        begin
            if (b == 0)
                dec_status = ST_ZERO;
            else if (b > budget)
                dec_status = ST_LIM;
            else
            begin
                budget     -= b;
                block_left = b;
            end
            return;
        end
        block_left--;
        if (bits_in <= 16)
        begin
            bit_acc = (bit_acc | (int'(b) << bits_in)) & 24'hFFFFFF;
            bits_in += 8;
        end
    endfunction

    function automatic result_t predict_step(logic mode, logic [7:0] b);
        result_t     res;
        int unsigned code;
        res = '0;
        if (mode == MODE_PUSH)
            push_stream_byte(b);
        else
        begin
            if (stack_cnt == 0 && dec_status != ST_END && bits_in >= width)
            begin
                code    = bit_acc & ((1 << width) - 1);
                bit_acc = bit_acc >> width;
                bits_in -= width;
                decode_code(code);
            end
            if (stack_cnt > 0)
            begin
                stack_cnt--;
                res.pixel       = pix_stack[stack_cnt];
                res.pixel_valid = 1'b1;
                n_pixels++;
            end
        end
        res.need_byte = (stack_cnt == 0 && bits_in < width);
        res.status    = dec_status;
        return res;
    endfunction

    function automatic void issue(logic mode, logic [7:0] b);
        request_q.push_back('{mode, b});
        pixel_q.push_back(predict_step(mode, b));
        n_requests++;
    endfunction

    // data byte, opening a sub-block first where none is open
    function automatic void push_data(logic [7:0] b);
        int unsigned top;
        top = (budget < 255) ? budget : 255;
        if (block_left == 0)
            issue(MODE_PUSH, 8'($urandom_range(top, 1)));
        issue(MODE_PUSH, b);
    endfunction

    // a chain may only pass through entries that have been written
    function automatic bit chain_known(int unsigned c);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (c <= clear_code() + 1 || c >= DEPTH)
                return 1'b1;
            if (!entry_set[c])
                return 1'b0;
            c = prefix_mem[c];
        end
        return 1'b1;
    endfunction

    function automatic bit code_allowed(int unsigned c);
        if (c == clear_code() + 1)
            return 1'b0;
        if (c == clear_code())
            return 1'b1;
        return chain_known((cleared || c < free_code) ? c : last_code);
    endfunction

    // choose a code whose low bits match what the accumulator already holds
    function automatic int unsigned pick_code(code_kind_t kind);
        code_kind_t  k;
        int unsigned target;
        int unsigned cand;
        int unsigned roll;
        int unsigned low_mask;
        low_mask = (1 << bits_in) - 1;
        for (int attempt = 0; attempt < 8; attempt++)
        begin
            k = kind;
            if (kind == K_ANY)
            begin
                roll = $urandom_range(99);
                k = (roll < 8) ? K_CLEAR : (roll < 48) ? K_ROOT : (roll < 78) ? K_OLD :
                    (roll < 90) ? K_KW : K_TOP;
            end
            case (k)
                K_ROOT:    target = $urandom_range(clear_code() - 1, 0);
                K_TOPROOT: target = clear_code() - 1;
                K_CLEAR:   target = clear_code();
                K_KW:      target = free_code;
                K_OLD:     target = (free_code > clear_code() + 2) ?
                                    $urandom_range(free_code - 1, clear_code() + 2) :
                                    clear_code() + 2;
                default:   target = $urandom_range((1 << width) - 1, 0);
            endcase
            cand = (target & ~low_mask & ((1 << width) - 1)) | bit_acc;
            if (code_allowed(cand))
                return cand;
        end
        // held bits alone always form a root
        return bit_acc;
    endfunction

    // append the missing bits of a code, the spare bits of the last byte form a root
    function automatic void pack_code(int unsigned code, bit zero_tail);
        int unsigned need;
        int unsigned nbytes;
        int unsigned spare;
        int unsigned tail_max;
        int unsigned tail;
        int unsigned bits;
        need     = width - bits_in;
        nbytes   = (need + 7) / 8;
        spare    = nbytes * 8 - need;
        tail_max = ((1 << spare) < clear_code()) ? (1 << spare) : clear_code();
        tail     = zero_tail ? 0 : $urandom_range(tail_max - 1, 0);
        bits     = (code >> bits_in) | (tail << need);
        for (int i = 0; i < nbytes; i++)
            push_data(8'(bits >> (8 * i)));
    endfunction

    function automatic void pull_pending();
        while ((bits_in >= width && dec_status != ST_END) || stack_cnt > 0)
        begin
            issue(MODE_PULL, 8'($urandom_range(255)));
            if ($urandom_range(19) == 0)
                issue(MODE_PULL, 8'($urandom_range(255)));
        end
    endfunction

    function automatic void send_code(code_kind_t kind, bit zero_tail);
        pull_pending();
        pack_code(pick_code(kind), zero_tail);
        pull_pending();
    endfunction

    // fill the accumulator with zero bytes, then bytes that are dropped
    function automatic void overfill();
        pull_pending();
        while (bits_in <= 16)
            push_data(8'h00);
        repeat ($urandom_range(3, 1))
            push_data(8'($urandom_range(255)));
        pull_pending();
    endfunction

    function automatic void random_stream(int count);
        int goal;
        int roll;
        goal = n_requests + count;
        while (n_requests < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                overfill();
            else if (roll < 9)
                issue(MODE_PULL, 8'($urandom_range(255)));
            else
                send_code(K_ANY, 1'b0);
        end
        // leave the accumulator empty of ones before any size change
        send_code(K_ROOT, 1'b1);
    endfunction

    task automatic wait_drained();
        while (request_q.size() != 0 || pixel_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_MIN_SIZE)
        begin
            min_size = value & 4'hF;
            restart_codes();
        end
        else
            budget = value & 24'hFFFFFF;
    endtask

    task automatic phase(int unsigned size_val, int unsigned limit_val, int count, int pct);
        write_reg(REG_MIN_SIZE, size_val);
        write_reg(REG_LIMIT, limit_val);
        idle_pct = pct;
        random_stream(count);
    endtask

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                if ($urandom_range(99) < idle_pct)
                begin
                    send_gap    <= $urandom_range(10, 0);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    r = request_q.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.mode      <= r.mode;
                    in_ch.data_byte <= r.data;
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_stall   <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (out_ch.pixel !== want.pixel)
                    begin
                        $error("pixel: expected %0d, got %0d", want.pixel, out_ch.pixel);
                        errors++;
                    end
                    if (out_ch.pixel_valid !== want.pixel_valid)
                    begin
                        $error("pixel_valid: expected %0d, got %0d", want.pixel_valid,
                               out_ch.pixel_valid);
                        errors++;
                    end
                    if (out_ch.need_byte !== want.need_byte)
                    begin
                        $error("need_byte: expected %0d, got %0d", want.need_byte,
                               out_ch.need_byte);
                        errors++;
                    end
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        errors++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall   <= sink_stall - 1;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < idle_pct)
            begin
                sink_stall   <= $urandom_range(10, 0);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog on stalled progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (request_q.size() == 0 && pixel_q.size() == 0))
                watchdog <= 0;
            else if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                watchdog <= watchdog + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_PUSH;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        errors          = 0;
        watchdog        = 0;
        idle_pct        = 10;

        // predicted state after reset
        min_size   = 8;
        budget     = 24'hFFFFFF;
        stack_cnt  = 0;
        bit_acc    = 0;
        bits_in    = 0;
        block_left = 0;
        last_code  = 0;
        cleared    = 1'b0;
        dec_status = ST_RUN;
        restart_codes();
        foreach (entry_set[i])
            entry_set[i] = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pulls, longest block, clear, top and random roots, kwkwk, known
        // code after a clear, full accumulator
        issue(MODE_PULL, 8'h00);
        issue(MODE_PULL, 8'hFF);
        issue(MODE_PUSH, 8'd255);
        send_code(K_CLEAR, 1'b0);
        send_code(K_TOPROOT, 1'b0);
        send_code(K_ROOT, 1'b0);
        send_code(K_KW, 1'b0);
        send_code(K_OLD, 1'b0);
        send_code(K_CLEAR, 1'b0);
        send_code(K_OLD, 1'b0);
        overfill();
        send_code(K_ROOT, 1'b1);

        // random streams over several code sizes, out of range ones included
        phase(8, 24'hFFFFFF, 450, 10);
        phase(0, 100000, 200, 25);
        phase(15, 24'hFFFFFF, 200, 0);
        phase(4, 5000, 200, 10);
        phase(2, 24'hFFFFFF, 200, 40);
        phase(1, 9000, 200, 10);
        phase(7, 24'hFFFFFF, 200, 10);

        // end: buffered end code, zero budget, over-budget length, ignored pushes
        idle_pct = 0;
        write_reg(REG_MIN_SIZE, 8);
        // empty the accumulator so that the end code lands on its own bits
        while (bits_in != 0)
            send_code(K_ROOT, 1'b1);
        pull_pending();
        pack_code(clear_code() + 1, 1'b1);
        write_reg(REG_LIMIT, 0);
        while (block_left > 0)
            issue(MODE_PUSH, 8'($urandom_range(255)));
        issue(MODE_PUSH, 8'($urandom_range(255, 1)));
        repeat (3)
            issue(MODE_PUSH, 8'($urandom_range(255)));
        repeat (3)
            issue(MODE_PULL, 8'($urandom_range(255)));

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d requests, %0d pixels, %0d clear codes, %0d kwkwk codes",
                 n_requests, n_pixels, n_clears, n_kwkwk);
        $display("%0d codes with a full table, final status %0d", n_full, dec_status);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
